// ===== hdl/sspl_pkg.sv =====
package sspl_pkg;
  localparam int SPEED_MAX = 65535;
  localparam int RUN_SPEED = 100;
  localparam int ANGLE_DIV = 18;
  localparam int PERMILLE  = 1000;

  localparam logic [2:0] REG_TOP    = 3'd0;
  localparam logic [2:0] REG_BOTTOM = 3'd1;
  localparam logic [2:0] REG_BAND   = 3'd2;
  localparam logic [2:0] REG_NUMER  = 3'd3;
  localparam logic [2:0] REG_K1     = 3'd4;
  localparam logic [2:0] REG_K2     = 3'd5;
  localparam logic [2:0] REG_K3     = 3'd6;
  localparam logic [2:0] REG_LIMIT  = 3'd7;

  typedef logic signed [16:0] err_t;
endpackage

// ===== hdl/stepper_speed_pid_loop.sv =====
// the input stalls from acceptance until the result word is registered, so a new word
// is taken only after the last one is through; a stalled result word holds the engine
// in its last state; the PID multiplies are skipped when speed is 100 or below
// dividers are restoring and multipliers shift-add, one bit a cycle
// synchronous active-low reset restores register defaults, clears errors, sets position 900
module stepper_speed_pid_loop import sspl_pkg::*; #(
  parameter int FRACTION_BITS = 8,
  parameter int POT_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [POT_BITS-1:0] in_pot_reading,
  input  logic [31:0]         in_tach_period,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [5:0]          out_step_count,
  output logic                out_step_direction,
  output logic [7:0]          out_valve_angle,
  output logic [15:0]         out_target_speed,
  output logic [15:0]         out_measured_speed,
  output logic                out_running,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int QW = 30;                       // position width
  localparam int PW = 48;                       // product/accumulator width
  localparam logic signed [QW-1:0] ONE_Q = QW'(1) <<< FRACTION_BITS;
  localparam logic signed [QW-1:0] CLAMP = QW'(48) * ONE_Q;
  localparam logic signed [QW-1:0] LOWB  = -(QW'(90) * ONE_Q);
  localparam logic [POT_BITS-1:0]  POT_FULL = {POT_BITS{1'b1}};
  localparam logic [QW-1:0] ADIV = QW'(ANGLE_DIV) << FRACTION_BITS;

  localparam logic [3:0] S_IDLE = 4'd0, S_SPAN = 4'd1, S_TDIV = 4'd2, S_BMUL = 4'd3,
                         S_BDIV = 4'd4, S_SDIV = 4'd5, S_ERR = 4'd6, S_MUL = 4'd7,
                         S_LIM = 4'd8, S_ADIV = 4'd9, S_OUT = 4'd10;

  logic [15:0] top_r, bot_r, numer_hi_unused;
  logic [9:0]  band_pm_r;
  logic [31:0] numer_r;
  logic [23:0] k1_r, k2_r, k3_r;
  logic [11:0] limit_r;

  logic [3:0]  st_r;
  logic [5:0]  cnt_r;
  logic [POT_BITS-1:0] pot_r;
  logic [31:0] per_r;
  // generic shift-subtract divider / shift-add multiplier datapath
  logic [PW-1:0] acc_r;     // partial remainder or product
  logic [PW-1:0] q_r;       // dividend/quotient or multiplier shift
  logic [PW-1:0] d_r;       // divisor or multiplicand
  logic          neg_r;
  logic [15:0] target_r, speed_r;
  logic [16:0] band_r;      // permille above 1000 can push the band past 16 bits
  err_t e0_r, e1_r, e2_r;
  logic [1:0]  fill_r;
  logic [1:0]  term_r;
  logic signed [PW-1:0] sum_r;
  logic signed [QW-1:0] pos_r, diff_r;
  logic        run_r;
  logic        ov_r;

  assign pready = 1'b1;
  assign numer_hi_unused = 16'd0;
  wire wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[4:2])
      REG_TOP:    prdata = {16'd0, top_r};
      REG_BOTTOM: prdata = {16'd0, bot_r};
      REG_BAND:   prdata = {22'd0, band_pm_r};
      REG_NUMER:  prdata = numer_r;
      REG_K1:     prdata = {{8{k1_r[23]}}, k1_r};
      REG_K2:     prdata = {{8{k2_r[23]}}, k2_r};
      REG_K3:     prdata = {{8{k3_r[23]}}, k3_r};
      REG_LIMIT:  prdata = {20'd0, limit_r};
      default:    prdata = {numer_hi_unused, 16'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= 16'd3000; bot_r <= '0; band_pm_r <= '0; numer_r <= '0;
      k1_r <= '0; k2_r <= '0; k3_r <= '0; limit_r <= 12'd1080;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_TOP:    top_r <= pwdata[15:0];
        REG_BOTTOM: bot_r <= pwdata[15:0];
        REG_BAND:   band_pm_r <= pwdata[9:0];
        REG_NUMER:  numer_r <= pwdata;
        REG_K1:     k1_r <= pwdata[23:0];
        REG_K2:     k2_r <= pwdata[23:0];
        REG_K3:     k3_r <= pwdata[23:0];
        REG_LIMIT:  limit_r <= pwdata[11:0];
        default:    ;
      endcase
    end
  end

  assign in_stall = (st_r != S_IDLE);

  // one restoring divide bit
  wire [PW:0] trial = {acc_r, q_r[PW-1]} - {1'b0, d_r};
  wire [PW-1:0] rem_sh = {acc_r[PW-2:0], q_r[PW-1]};

  logic signed [16:0] span;
  logic signed [24:0] gsel;
  logic signed [16:0] esel;
  logic signed [QW-1:0] upper, dsat, d1, d2;
  logic signed [PW-1:0] sum_c;
  logic [16:0] tgt_b;
  always_comb begin
    span = $signed({1'b0, top_r}) - $signed({1'b0, bot_r});
    case (term_r)
      2'd0: begin gsel = {k1_r[23], k1_r}; esel = e0_r; end
      2'd1: begin gsel = {k2_r[23], k2_r}; esel = e1_r; end
      default: begin gsel = {k3_r[23], k3_r}; esel = e2_r; end
    endcase
    tgt_b = {1'b0, target_r};
    upper = (QW'(limit_r) + QW'(90)) <<< FRACTION_BITS;
    sum_c = sum_r;
    if (sum_c > PW'(CLAMP)) dsat = CLAMP;
    else if (sum_c < -PW'(CLAMP)) dsat = -CLAMP;
    else dsat = sum_c[QW-1:0];
    d1 = dsat;
    if (pos_r + d1 > upper) d1 = upper - pos_r;
    if (pos_r + d1 < LOWB) d1 = LOWB - pos_r;
    d2 = (d1 > CLAMP) ? CLAMP : ((d1 < -CLAMP) ? -CLAMP : d1);
  end

  wire signed [QW-1:0] dabs = diff_r[QW-1] ? -diff_r : diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_valid <= 1'b0; fill_r <= '0; run_r <= 1'b0;
      e0_r <= '0; e1_r <= '0; e2_r <= '0;
      pos_r <= QW'(900) <<< FRACTION_BITS;
    end else begin
      if (out_valid && !out_stall && st_r != S_OUT) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          pot_r <= in_pot_reading; per_r <= in_tach_period;
          st_r <= S_SPAN;
        end
        S_SPAN: begin   // start pot*|span| via shift-add
          neg_r <= span[16];
          acc_r <= '0;
          q_r <= PW'(pot_r);
          d_r <= PW'(span[16] ? -span : span);
          cnt_r <= 6'(POT_BITS);
          st_r <= S_BMUL;
          term_r <= 2'd3;
        end
        S_BMUL: begin
          if (cnt_r != 0) begin
            if (q_r[0]) acc_r <= acc_r + d_r;
            d_r <= d_r << 1; q_r <= q_r >> 1; cnt_r <= cnt_r - 6'd1;
          end else if (term_r == 2'd3) begin  // divide product by pot full scale
            q_r <= acc_r << (PW - 32); acc_r <= '0;
            d_r <= PW'(POT_FULL); cnt_r <= 6'd32; st_r <= S_TDIV;
          end else begin                      // divide band product by 1000
            q_r <= acc_r << (PW - 32); acc_r <= '0;
            d_r <= PW'(PERMILLE); cnt_r <= 6'd32; st_r <= S_BDIV;
          end
        end
        S_TDIV: begin
          if (cnt_r != 0) begin
            if (!trial[PW]) begin acc_r <= trial[PW-1:0]; q_r <= {q_r[PW-2:0], 1'b1}; end
            else begin acc_r <= rem_sh; q_r <= {q_r[PW-2:0], 1'b0}; end
            cnt_r <= cnt_r - 6'd1;
          end else begin
            target_r <= neg_r ? bot_r - q_r[15:0] : bot_r + q_r[15:0];
            acc_r <= '0; q_r <= PW'(band_pm_r);
            d_r <= PW'(neg_r ? bot_r - q_r[15:0] : bot_r + q_r[15:0]);
            cnt_r <= 6'd10; term_r <= 2'd2; st_r <= S_BMUL;
          end
        end
        S_BDIV: begin
          if (cnt_r != 0) begin
            if (!trial[PW]) begin acc_r <= trial[PW-1:0]; q_r <= {q_r[PW-2:0], 1'b1}; end
            else begin acc_r <= rem_sh; q_r <= {q_r[PW-2:0], 1'b0}; end
            cnt_r <= cnt_r - 6'd1;
          end else begin
            band_r <= q_r[16:0];
            acc_r <= '0; q_r <= {numer_r, 16'd0}; d_r <= PW'(per_r);
            cnt_r <= 6'd32; ov_r <= 1'b0; st_r <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (cnt_r != 0) begin
            if (!trial[PW]) begin acc_r <= trial[PW-1:0]; q_r <= {q_r[PW-2:0], 1'b1}; end
            else begin acc_r <= rem_sh; q_r <= {q_r[PW-2:0], 1'b0}; end
            cnt_r <= cnt_r - 6'd1;
          end else begin
            if (per_r == 32'd0 || q_r[31:16] != 16'd0) speed_r <= 16'hFFFF;
            else speed_r <= q_r[15:0];
            st_r <= S_ERR;
          end
        end
        S_ERR: begin : err_blk
          logic [16:0] sp;
          sp = {1'b0, speed_r};
          if ({1'b0, sp} + {1'b0, band_r} > {1'b0, tgt_b}
              && {1'b0, sp} < {1'b0, tgt_b} + {1'b0, band_r}) sp = tgt_b;
          speed_r <= sp[15:0];
          if (sp > 17'(RUN_SPEED)) run_r <= 1'b1;
          e0_r <= $signed(tgt_b) - $signed(sp);
          if (fill_r != 2'd0) e1_r <= e0_r;
          if (fill_r[1]) e2_r <= e1_r;
          if (fill_r != 2'd2) fill_r <= fill_r + 2'd1;
          sum_r <= (sp > 17'(RUN_SPEED)) ? '0 : -PW'(CLAMP);
          ov_r <= !(sp > 17'(RUN_SPEED));
          term_r <= 2'd0; cnt_r <= 6'd17; st_r <= S_MUL;
          acc_r <= '0;
        end
        S_MUL: begin   // serial signed product, multiplier bit per cycle
          if (ov_r) st_r <= S_LIM;
          else if (cnt_r != 0) begin
            if (esel[5'(6'd17 - cnt_r)]) begin
              if (cnt_r == 6'd1) acc_r <= acc_r - (PW'(gsel) <<< (6'd16));
              else acc_r <= acc_r + (PW'(gsel) <<< (6'd17 - cnt_r));
            end
            cnt_r <= cnt_r - 6'd1;
          end else begin
            sum_r <= sum_r + acc_r; acc_r <= '0; cnt_r <= 6'd17;
            if (term_r == 2'd2) st_r <= S_LIM; else term_r <= term_r + 2'd1;
          end
        end
        S_LIM: begin
          diff_r <= d2; pos_r <= pos_r + d2;
          acc_r <= '0; q_r <= PW'(pos_r + d2) << (PW - QW);
          d_r <= PW'(ADIV); cnt_r <= 6'(QW); st_r <= S_ADIV;
        end
        S_ADIV: begin
          if (cnt_r != 0) begin
            if (!trial[PW]) begin acc_r <= trial[PW-1:0]; q_r <= {q_r[PW-2:0], 1'b1}; end
            else begin acc_r <= rem_sh; q_r <= {q_r[PW-2:0], 1'b0}; end
            cnt_r <= cnt_r - 6'd1;
          end else st_r <= S_OUT;
        end
        S_OUT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          out_step_count <= 6'(dabs >>> FRACTION_BITS);
          out_step_direction <= diff_r[QW-1] && (dabs >= ONE_Q);
          out_valve_angle <= (pos_r <= 0) ? 8'd0 : q_r[7:0];
          out_target_speed <= target_r;
          out_measured_speed <= speed_r;
          out_running <= run_r;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_step_count <= 6'd48) else $error("step count above clamp");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3) else $error("fill count overflow");
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    $past(run_r) |-> run_r) else $error("running flag dropped");
endmodule
